// ----- rtl/ngga_pkg.sv -----
package ngga_pkg;

   // Default sizes
   localparam int MAX_FIELD_CHARS_DEF = 20;
   localparam int FRAC_DIGITS_DEF     = 5;

   // Fixed widths
   localparam int INT_DIGITS  = 5;
   localparam int INT_W       = 17;   // up to 99999
   localparam int ICNT_W      = 3;
   localparam int FCNT_W      = 3;
   localparam int FIELD_NUM_W = 5;
   localparam int COORD_W     = 35;
   localparam int MAG_W       = 34;
   localparam int STATUS_W    = 3;
   localparam int COORD_LAT   = 6;    // register stages inside ngga_coord

   localparam logic [MAG_W-1:0] MAG_LIMIT = 34'd10100000000;

   // Reciprocal constants for division by a constant
   localparam logic [17:0] DIV100_MUL   = 18'd167773;     // ceil(2^24/100)
   localparam int          DIV100_SHIFT = 24;
   localparam logic [15:0] DIV15S_MUL   = 16'd34953;      // ceil(2^19/15)
   localparam int          DIV15S_SHIFT = 19;
   localparam logic [28:0] DIV15L_MUL   = 29'd286331154;  // ceil(2^32/15)
   localparam int          DIV15L_SHIFT = 32;
   localparam logic [23:0] TEN_E7       = 24'd10000000;

   // Field positions in the sentence
   localparam logic [FIELD_NUM_W-1:0] FIELD_LAT     = 5'd2;
   localparam logic [FIELD_NUM_W-1:0] FIELD_LAT_DIR = 5'd3;
   localparam logic [FIELD_NUM_W-1:0] FIELD_LON     = 5'd4;
   localparam logic [FIELD_NUM_W-1:0] FIELD_LON_DIR = 5'd5;
   localparam logic [FIELD_NUM_W-1:0] FIELD_NUM_MAX = 5'd31;

   localparam logic [2:0] TAG_LEN = 3'd6;

   // Characters
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_POINT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_E      = 8'h45;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_GGA      = 3'd1,
      KIND_OTHER    = 3'd2,
      KIND_EMPTY    = 3'd3,
      KIND_BADSTART = 3'd4
   } line_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_EMPTY    = 3'd1,
      STATUS_BADSTART = 3'd2,
      STATUS_DROPPED  = 3'd3,
      STATUS_OTHER    = 3'd4
   } status_type;

   // "$GPGGA" by position
   function automatic logic [7:0] gga_tag_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0: ch = 8'h24;
         3'd1: ch = 8'h47;
         3'd2: ch = 8'h50;
         3'd3: ch = 8'h47;
         3'd4: ch = 8'h47;
         3'd5: ch = 8'h41;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [23:0] pow10(input logic [2:0] idx);
      logic [23:0] p;
      case (idx)
         3'd0: p = 24'd1;
         3'd1: p = 24'd10;
         3'd2: p = 24'd100;
         3'd3: p = 24'd1000;
         3'd4: p = 24'd10000;
         3'd5: p = 24'd100000;
         3'd6: p = 24'd1000000;
         3'd7: p = 24'd10000000;
         default: p = 24'd1;
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/ngga_coord.sv -----
// Coordinate field to signed 1e-7 degrees, six register stages.
module ngga_coord #(
   parameter int FRAC_DIGITS = ngga_pkg::FRAC_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [ngga_pkg::INT_W-1:0]        int_value,
   input  logic [$clog2(10**FRAC_DIGITS)-1:0] frac_value,
   input  logic [ngga_pkg::FCNT_W-1:0]       frac_count,
   input  logic                              point,
   input  logic                              negative,
   output logic signed [ngga_pkg::COORD_W-1:0] coord
);

   localparam int FRAC_W = $clog2(10**FRAC_DIGITS);
   localparam int INT_W  = ngga_pkg::INT_W;

   // stage 1: degrees = int / 100, fraction scaled to 1e-7 minutes
   logic [34:0]      deg_prod;
   logic [10:0]      deg1_in, deg1_ff;
   logic [FRAC_W+23:0] fx_prod;
   logic [23:0]      fx1_in, fx1_ff;
   logic [INT_W-1:0] int1_ff;
   logic             neg1_ff;

   // stage 2: minutes integer part
   logic [INT_W-1:0] mint2_in, mint2_ff;
   logic [10:0]      deg2_ff;
   logic [23:0]      fx2_ff;
   logic             neg2_ff;

   // stage 3: whole minutes / 60
   logic [31:0]      a_prod;
   logic [10:0]      a3_in, a3_ff;
   logic [INT_W-1:0] mint3_ff;
   logic [10:0]      deg3_ff;
   logic [23:0]      fx3_ff;
   logic             neg3_ff;

   // stage 4: leftover minutes in 1e-7 units, whole degrees
   logic [5:0]       r4;
   logic [29:0]      y4_in, y4_ff;
   logic [11:0]      ds4_in, ds4_ff;
   logic             neg4_ff;

   // stage 5: leftover / 60, whole degrees scaled
   logic [63:0]      q_prod;
   logic [23:0]      q5_in, q5_ff;
   logic [34:0]      dsm5_in, dsm5_ff;
   logic             neg5_ff;

   // output stage
   logic [35:0]                         mag_sum;
   logic [ngga_pkg::MAG_W-1:0]          mag_sat;
   logic signed [ngga_pkg::COORD_W-1:0] coord_in, coord_ff;

   always_comb begin
      deg_prod = 35'(int_value) * 35'(ngga_pkg::DIV100_MUL);
      deg1_in  = point ? 11'(deg_prod >> ngga_pkg::DIV100_SHIFT) : 11'd0;
      fx_prod  = (FRAC_W+24)'(frac_value)
                 * (FRAC_W+24)'(ngga_pkg::pow10(3'd7 - frac_count));
      fx1_in   = fx_prod[23:0];

      mint2_in = int1_ff - INT_W'(INT_W'(deg1_ff) * INT_W'(100));

      a_prod   = 32'(mint2_ff[INT_W-1:2]) * 32'(ngga_pkg::DIV15S_MUL);
      a3_in    = 11'(a_prod >> ngga_pkg::DIV15S_SHIFT);

      r4       = 6'(mint3_ff - INT_W'(INT_W'(a3_ff) * INT_W'(60)));
      y4_in    = 30'(30'(r4) * 30'(ngga_pkg::TEN_E7)) + 30'(fx3_ff);
      ds4_in   = 12'(deg3_ff) + 12'(a3_ff);

      q_prod   = 64'(y4_ff[29:2]) * 64'(ngga_pkg::DIV15L_MUL);
      q5_in    = 24'(q_prod >> ngga_pkg::DIV15L_SHIFT);
      dsm5_in  = 35'(ds4_ff) * 35'(ngga_pkg::TEN_E7);

      mag_sum  = 36'(dsm5_ff) + 36'(q5_ff);
      mag_sat  = (mag_sum > 36'(ngga_pkg::MAG_LIMIT)) ? ngga_pkg::MAG_LIMIT
                                                       : mag_sum[ngga_pkg::MAG_W-1:0];
      coord_in = neg5_ff ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg1_ff  <= deg1_in;
         fx1_ff   <= fx1_in;
         int1_ff  <= int_value;
         neg1_ff  <= negative;

         mint2_ff <= mint2_in;
         deg2_ff  <= deg1_ff;
         fx2_ff   <= fx1_ff;
         neg2_ff  <= neg1_ff;

         a3_ff    <= a3_in;
         mint3_ff <= mint2_ff;
         deg3_ff  <= deg2_ff;
         fx3_ff   <= fx2_ff;
         neg3_ff  <= neg2_ff;

         y4_ff    <= y4_in;
         ds4_ff   <= ds4_in;
         neg4_ff  <= neg3_ff;

         q5_ff    <= q5_in;
         dsm5_ff  <= dsm5_in;
         neg5_ff  <= neg4_ff;

         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

// ----- rtl/nmea_gga_position_parser.sv -----
// NMEA GGA position parser.
// Input channel (req_valid / req_stall / req_rx_byte): one received character per
// word, accepted on a clock edge with req_valid high and req_stall low.
// Result channel (rsp_valid / rsp_stall / rsp_status / rsp_latitude / rsp_longitude):
// one word per line feed; no other character produces a word. Latitude and
// longitude are signed 1e-7 degree values, zero unless the status is OK.
// Throughput: one character per cycle, sustained, while the result side takes words.
// A line feed's result word reaches rsp_* through the input register, the line
// snapshot and six stages of coordinate arithmetic.
// The arithmetic chain (divide by 100, minutes divided by 60 through reciprocal
// multiplies, scaling by 1e7) sets the stage count.
// When rsp_stall holds a valid result, the whole pipeline freezes; a skid register
// takes one more character, after which req_stall rises (it is a registered signal).
// Reset (synchronous, active high) empties the pipeline and puts the parser at the
// start of a line; the first result word follows the first line feed after reset.
module nmea_gga_position_parser #(
   parameter int MAX_FIELD_CHARS        = ngga_pkg::MAX_FIELD_CHARS_DEF,
   parameter int MINUTE_FRACTION_DIGITS = ngga_pkg::FRAC_DIGITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ngga_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [ngga_pkg::COORD_W-1:0] rsp_latitude,
   output logic signed [ngga_pkg::COORD_W-1:0] rsp_longitude
);

   localparam int FRAC_W = $clog2(10**MINUTE_FRACTION_DIGITS);
   localparam int LEN_W  = $clog2(MAX_FIELD_CHARS + 1);
   localparam int INT_W  = ngga_pkg::INT_W;
   localparam int FCNT_W = ngga_pkg::FCNT_W;
   localparam int ICNT_W = ngga_pkg::ICNT_W;
   localparam int FN_W   = ngga_pkg::FIELD_NUM_W;
   localparam int PIPE_N = ngga_pkg::COORD_LAT - 1;

   // ---------------- input register and skid ----------------
   logic       adv;        // pipeline moves this cycle
   logic       req_acc;
   logic       proc;       // parser consumes byte_ff
   logic       skid_vld_ff;
   logic [7:0] skid_byte_ff;
   logic       byte_vld_ff;
   logic [7:0] byte_ff;
   logic       rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !skid_vld_ff;
   assign req_stall = skid_vld_ff;
   assign proc      = adv && byte_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (adv) begin
         byte_vld_ff <= skid_vld_ff || req_acc;
         skid_vld_ff <= 1'b0;
      end else if (req_acc) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byte_ff <= skid_vld_ff ? skid_byte_ff : req_rx_byte;
      end else if (req_acc) begin
         skid_byte_ff <= req_rx_byte;
      end
   end

   // ---------------- parser state ----------------
   logic                    at_start_ff, at_start_in;
   ngga_pkg::line_kind_type kind_ff, kind_in;
   logic [2:0]              hpos_ff, hpos_in;
   logic [FN_W-1:0]         fnum_ff, fnum_in;
   logic                    bad_ff, bad_in;

   // field being received
   logic [LEN_W-1:0]  fld_len_ff, fld_len_in;
   logic [INT_W-1:0]  fld_int_ff, fld_int_in;
   logic [ICNT_W-1:0] fld_icnt_ff, fld_icnt_in;
   logic [FRAC_W-1:0] fld_frac_ff, fld_frac_in;
   logic [FCNT_W-1:0] fld_fcnt_ff, fld_fcnt_in;
   logic              fld_point_ff, fld_point_in;

   // coordinate fields kept as raw digits; converted after the line ends
   logic [INT_W-1:0]  lat_int_ff, lat_int_in, lon_int_ff, lon_int_in;
   logic [FRAC_W-1:0] lat_frac_ff, lat_frac_in, lon_frac_ff, lon_frac_in;
   logic [FCNT_W-1:0] lat_fcnt_ff, lat_fcnt_in, lon_fcnt_ff, lon_fcnt_in;
   logic              lat_point_ff, lat_point_in, lon_point_ff, lon_point_in;
   logic              lat_neg_ff, lat_neg_in, lon_neg_ff, lon_neg_in;

   // field close: state with the current field folded in
   logic              end_bad;
   logic [INT_W-1:0]  end_lat_int, end_lon_int;
   logic [FRAC_W-1:0] end_lat_frac, end_lon_frac;
   logic [FCNT_W-1:0] end_lat_fcnt, end_lon_fcnt;
   logic              end_lat_point, end_lon_point;

   logic              is_coord, is_dir, is_digit;
   logic [3:0]        digit;

   // line snapshot (stage 0)
   logic                        snap_vld_in, snap_vld_ff;
   ngga_pkg::status_type        snap_status_in, snap_status_ff;
   logic [INT_W-1:0]            snap_lat_int_in, snap_lat_int_ff;
   logic [INT_W-1:0]            snap_lon_int_in, snap_lon_int_ff;
   logic [FRAC_W-1:0]           snap_lat_frac_in, snap_lat_frac_ff;
   logic [FRAC_W-1:0]           snap_lon_frac_in, snap_lon_frac_ff;
   logic [FCNT_W-1:0]           snap_lat_fcnt_in, snap_lat_fcnt_ff;
   logic [FCNT_W-1:0]           snap_lon_fcnt_in, snap_lon_fcnt_ff;
   logic                        snap_lat_point_in, snap_lat_point_ff;
   logic                        snap_lon_point_in, snap_lon_point_ff;
   logic                        snap_lat_neg_in, snap_lat_neg_ff;
   logic                        snap_lon_neg_in, snap_lon_neg_ff;

   always_comb begin
      // field close
      end_bad       = bad_ff;
      end_lat_int   = lat_int_ff;
      end_lat_frac  = lat_frac_ff;
      end_lat_fcnt  = lat_fcnt_ff;
      end_lat_point = lat_point_ff;
      end_lon_int   = lon_int_ff;
      end_lon_frac  = lon_frac_ff;
      end_lon_fcnt  = lon_fcnt_ff;
      end_lon_point = lon_point_ff;
      is_coord = (fnum_ff == ngga_pkg::FIELD_LAT) || (fnum_ff == ngga_pkg::FIELD_LON);
      is_dir   = (fnum_ff == ngga_pkg::FIELD_LAT_DIR) || (fnum_ff == ngga_pkg::FIELD_LON_DIR);
      if (is_coord) begin
         if (fld_len_ff >= LEN_W'(MAX_FIELD_CHARS)) begin
            end_bad = 1'b1;
         end
         if (!end_bad) begin
            if (fnum_ff == ngga_pkg::FIELD_LAT) begin
               end_lat_int   = fld_int_ff;
               end_lat_frac  = fld_frac_ff;
               end_lat_fcnt  = fld_fcnt_ff;
               end_lat_point = fld_point_ff;
            end else begin
               end_lon_int   = fld_int_ff;
               end_lon_frac  = fld_frac_ff;
               end_lon_fcnt  = fld_fcnt_ff;
               end_lon_point = fld_point_ff;
            end
         end
      end

      is_digit = (byte_ff >= ngga_pkg::CHAR_ZERO) && (byte_ff <= ngga_pkg::CHAR_NINE);
      digit    = 4'(byte_ff - ngga_pkg::CHAR_ZERO);

      // hold by default
      at_start_in  = at_start_ff;
      kind_in      = kind_ff;
      hpos_in      = hpos_ff;
      fnum_in      = fnum_ff;
      bad_in       = bad_ff;
      fld_len_in   = fld_len_ff;
      fld_int_in   = fld_int_ff;
      fld_icnt_in  = fld_icnt_ff;
      fld_frac_in  = fld_frac_ff;
      fld_fcnt_in  = fld_fcnt_ff;
      fld_point_in = fld_point_ff;
      lat_int_in   = lat_int_ff;
      lat_frac_in  = lat_frac_ff;
      lat_fcnt_in  = lat_fcnt_ff;
      lat_point_in = lat_point_ff;
      lat_neg_in   = lat_neg_ff;
      lon_int_in   = lon_int_ff;
      lon_frac_in  = lon_frac_ff;
      lon_fcnt_in  = lon_fcnt_ff;
      lon_point_in = lon_point_ff;
      lon_neg_in   = lon_neg_ff;

      snap_vld_in       = 1'b0;
      snap_status_in    = ngga_pkg::STATUS_OK;
      snap_lat_int_in   = '0;
      snap_lat_frac_in  = '0;
      snap_lat_fcnt_in  = '0;
      snap_lat_point_in = 1'b0;
      snap_lat_neg_in   = 1'b0;
      snap_lon_int_in   = '0;
      snap_lon_frac_in  = '0;
      snap_lon_fcnt_in  = '0;
      snap_lon_point_in = 1'b0;
      snap_lon_neg_in   = 1'b0;

      if (proc) begin
         if (byte_ff == ngga_pkg::CHAR_LF) begin
            snap_vld_in = 1'b1;
            if (at_start_ff || kind_ff == ngga_pkg::KIND_EMPTY) begin
               snap_status_in = ngga_pkg::STATUS_EMPTY;
            end else if (kind_ff == ngga_pkg::KIND_BADSTART) begin
               snap_status_in = ngga_pkg::STATUS_BADSTART;
            end else if (kind_ff != ngga_pkg::KIND_GGA) begin
               snap_status_in = ngga_pkg::STATUS_OTHER;
            end else if (end_bad) begin
               snap_status_in = ngga_pkg::STATUS_DROPPED;
            end else begin
               snap_status_in    = ngga_pkg::STATUS_OK;
               snap_lat_int_in   = end_lat_int;
               snap_lat_frac_in  = end_lat_frac;
               snap_lat_fcnt_in  = end_lat_fcnt;
               snap_lat_point_in = end_lat_point;
               snap_lat_neg_in   = lat_neg_ff;
               snap_lon_int_in   = end_lon_int;
               snap_lon_frac_in  = end_lon_frac;
               snap_lon_fcnt_in  = end_lon_fcnt;
               snap_lon_point_in = end_lon_point;
               snap_lon_neg_in   = lon_neg_ff;
            end
            // back to start of line
            at_start_in  = 1'b1;
            kind_in      = ngga_pkg::KIND_HEADER;
            hpos_in      = 3'd0;
            fnum_in      = '0;
            bad_in       = 1'b0;
            lat_int_in   = '0;
            lat_frac_in  = '0;
            lat_fcnt_in  = '0;
            lat_point_in = 1'b0;
            lat_neg_in   = 1'b1;
            lon_int_in   = '0;
            lon_frac_in  = '0;
            lon_fcnt_in  = '0;
            lon_point_in = 1'b0;
            lon_neg_in   = 1'b1;
            fld_len_in   = '0;
            fld_int_in   = '0;
            fld_icnt_in  = '0;
            fld_frac_in  = '0;
            fld_fcnt_in  = '0;
            fld_point_in = 1'b0;
         end else if (at_start_ff) begin
            at_start_in = 1'b0;
            if (byte_ff == ngga_pkg::CHAR_NUL) begin
               kind_in = ngga_pkg::KIND_EMPTY;
            end else if (byte_ff == ngga_pkg::CHAR_DOLLAR) begin
               kind_in = ngga_pkg::KIND_HEADER;
               hpos_in = 3'd1;
            end else begin
               kind_in = ngga_pkg::KIND_BADSTART;
            end
         end else if (kind_ff == ngga_pkg::KIND_HEADER) begin
            if (hpos_ff < ngga_pkg::TAG_LEN && byte_ff == ngga_pkg::gga_tag_char(hpos_ff)) begin
               hpos_in = hpos_ff + 3'd1;
               if (hpos_in == ngga_pkg::TAG_LEN) begin
                  kind_in = ngga_pkg::KIND_GGA;
               end
            end else begin
               kind_in = ngga_pkg::KIND_OTHER;
            end
         end else if (kind_ff == ngga_pkg::KIND_GGA) begin
            if (byte_ff == ngga_pkg::CHAR_COMMA) begin
               bad_in       = end_bad;
               lat_int_in   = end_lat_int;
               lat_frac_in  = end_lat_frac;
               lat_fcnt_in  = end_lat_fcnt;
               lat_point_in = end_lat_point;
               lon_int_in   = end_lon_int;
               lon_frac_in  = end_lon_frac;
               lon_fcnt_in  = end_lon_fcnt;
               lon_point_in = end_lon_point;
               fld_len_in   = '0;
               fld_int_in   = '0;
               fld_icnt_in  = '0;
               fld_frac_in  = '0;
               fld_fcnt_in  = '0;
               fld_point_in = 1'b0;
               if (fnum_ff < ngga_pkg::FIELD_NUM_MAX) begin
                  fnum_in = fnum_ff + FN_W'(1);
               end
            end else begin
               if (fld_len_ff < LEN_W'(MAX_FIELD_CHARS)) begin
                  fld_len_in = fld_len_ff + LEN_W'(1);
               end
               if (is_dir) begin
                  // first character of a direction field sets the sign
                  if (fld_len_ff == '0) begin
                     if (fnum_ff == ngga_pkg::FIELD_LAT_DIR) begin
                        lat_neg_in = !(byte_ff == ngga_pkg::CHAR_N
                                       || byte_ff == ngga_pkg::CHAR_E);
                     end else begin
                        lon_neg_in = !(byte_ff == ngga_pkg::CHAR_N
                                       || byte_ff == ngga_pkg::CHAR_E);
                     end
                  end
               end else if (is_coord) begin
                  if (is_digit) begin
                     if (!fld_point_ff) begin
                        if (fld_icnt_ff < ICNT_W'(ngga_pkg::INT_DIGITS)) begin
                           fld_int_in  = INT_W'(fld_int_ff * INT_W'(10)) + INT_W'(digit);
                           fld_icnt_in = fld_icnt_ff + ICNT_W'(1);
                        end else begin
                           bad_in = 1'b1;
                        end
                     end else if (fld_fcnt_ff < FCNT_W'(MINUTE_FRACTION_DIGITS)) begin
                        // later fraction digits are dropped
                        fld_frac_in = FRAC_W'(fld_frac_ff * FRAC_W'(10)) + FRAC_W'(digit);
                        fld_fcnt_in = fld_fcnt_ff + FCNT_W'(1);
                     end
                  end else if (byte_ff == ngga_pkg::CHAR_POINT) begin
                     if (fld_point_ff) begin
                        bad_in = 1'b1;
                     end
                     fld_point_in = 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff  <= 1'b1;
         kind_ff      <= ngga_pkg::KIND_HEADER;
         hpos_ff      <= 3'd0;
         fnum_ff      <= '0;
         bad_ff       <= 1'b0;
         fld_len_ff   <= '0;
         fld_int_ff   <= '0;
         fld_icnt_ff  <= '0;
         fld_frac_ff  <= '0;
         fld_fcnt_ff  <= '0;
         fld_point_ff <= 1'b0;
         lat_int_ff   <= '0;
         lat_frac_ff  <= '0;
         lat_fcnt_ff  <= '0;
         lat_point_ff <= 1'b0;
         lat_neg_ff   <= 1'b1;
         lon_int_ff   <= '0;
         lon_frac_ff  <= '0;
         lon_fcnt_ff  <= '0;
         lon_point_ff <= 1'b0;
         lon_neg_ff   <= 1'b1;
      end else begin
         at_start_ff  <= at_start_in;
         kind_ff      <= kind_in;
         hpos_ff      <= hpos_in;
         fnum_ff      <= fnum_in;
         bad_ff       <= bad_in;
         fld_len_ff   <= fld_len_in;
         fld_int_ff   <= fld_int_in;
         fld_icnt_ff  <= fld_icnt_in;
         fld_frac_ff  <= fld_frac_in;
         fld_fcnt_ff  <= fld_fcnt_in;
         fld_point_ff <= fld_point_in;
         lat_int_ff   <= lat_int_in;
         lat_frac_ff  <= lat_frac_in;
         lat_fcnt_ff  <= lat_fcnt_in;
         lat_point_ff <= lat_point_in;
         lat_neg_ff   <= lat_neg_in;
         lon_int_ff   <= lon_int_in;
         lon_frac_ff  <= lon_frac_in;
         lon_fcnt_ff  <= lon_fcnt_in;
         lon_point_ff <= lon_point_in;
         lon_neg_ff   <= lon_neg_in;
      end
   end

   // ---------------- line snapshot ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_vld_ff <= 1'b0;
      end else if (adv) begin
         snap_vld_ff <= snap_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         snap_status_ff    <= snap_status_in;
         snap_lat_int_ff   <= snap_lat_int_in;
         snap_lat_frac_ff  <= snap_lat_frac_in;
         snap_lat_fcnt_ff  <= snap_lat_fcnt_in;
         snap_lat_point_ff <= snap_lat_point_in;
         snap_lat_neg_ff   <= snap_lat_neg_in;
         snap_lon_int_ff   <= snap_lon_int_in;
         snap_lon_frac_ff  <= snap_lon_frac_in;
         snap_lon_fcnt_ff  <= snap_lon_fcnt_in;
         snap_lon_point_ff <= snap_lon_point_in;
         snap_lon_neg_ff   <= snap_lon_neg_in;
      end
   end

   // ---------------- coordinate arithmetic ----------------
   ngga_coord #(
      .FRAC_DIGITS (MINUTE_FRACTION_DIGITS)
   ) u_lat (
      .clock      (clock),
      .en         (adv),
      .int_value  (snap_lat_int_ff),
      .frac_value (snap_lat_frac_ff),
      .frac_count (snap_lat_fcnt_ff),
      .point      (snap_lat_point_ff),
      .negative   (snap_lat_neg_ff),
      .coord      (rsp_latitude)
   );

   ngga_coord #(
      .FRAC_DIGITS (MINUTE_FRACTION_DIGITS)
   ) u_lon (
      .clock      (clock),
      .en         (adv),
      .int_value  (snap_lon_int_ff),
      .frac_value (snap_lon_frac_ff),
      .frac_count (snap_lon_fcnt_ff),
      .point      (snap_lon_point_ff),
      .negative   (snap_lon_neg_ff),
      .coord      (rsp_longitude)
   );

   // valid and status ride alongside the arithmetic stages
   logic                 pipe_vld_ff [PIPE_N];
   ngga_pkg::status_type pipe_status_ff [PIPE_N];
   ngga_pkg::status_type rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_N; i++) begin
            pipe_vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pipe_vld_ff[0] <= snap_vld_ff;
         for (int i = 1; i < PIPE_N; i++) begin
            pipe_vld_ff[i] <= pipe_vld_ff[i-1];
         end
         rsp_valid_ff <= pipe_vld_ff[PIPE_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_status_ff[0] <= snap_status_ff;
         for (int i = 1; i < PIPE_N; i++) begin
            pipe_status_ff[i] <= pipe_status_ff[i-1];
         end
         rsp_status_ff <= pipe_status_ff[PIPE_N-1];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule
